// File: hw/rtl/orso_pkg.sv
package orso_pkg;

  localparam logic [16:0] POLY_A = 17'd102944;
  localparam logic [16:0] POLY_B = 17'd42047;
  localparam logic [16:0] POLY_C = 17'd4640;

  localparam int unsigned SIN_W   = 16;
  localparam int unsigned QDEPTH  = 8;
  localparam int unsigned QPTR_W  = 3;
  localparam int unsigned QLVL_W  = 4;
  localparam int unsigned FSTAGES = 4;

  typedef struct packed {
    logic [QLVL_W-1:0] level;
    logic              empty;
  } fifo_stat_t;

endpackage

// File: hw/rtl/oriented_rect_overlap_sat.sv
// Oriented rectangle collision by the separating axis test.
// Input channel: in_valid_i / in_stall_o carry one rectangle pair per item
// (top-left, width, height in 1/16 pixel; binary angle, full turn 2^ANGLE_WIDTH).
// Output channel: out_valid_o / out_stall_i carry one overlap_o bit per item,
// 1 when the rectangles touch or intersect.
// Throughput: one item per cycle while out_stall_i is low; the front sine pipeline
// (4 stages) feeds an 8-entry queue, the back projection pipeline (4 stages) drains it.
// The input stalls when the queue plus front items in flight would exceed
// 8 entries, so a stalled output backs up into in_stall_o after a few items.
// A stalled output holds overlap_o and out_valid_o until taken.
// Reset clears all valid flags and the queue; in_stall_o is low after reset.
module oriented_rect_overlap_sat #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] a_left_i,
  input  logic signed [COORD_WIDTH-1:0] a_top_i,
  input  logic [COORD_WIDTH-2:0]        a_width_i,
  input  logic [COORD_WIDTH-2:0]        a_height_i,
  input  logic [ANGLE_WIDTH-1:0]        a_angle_i,
  input  logic signed [COORD_WIDTH-1:0] b_left_i,
  input  logic signed [COORD_WIDTH-1:0] b_top_i,
  input  logic [COORD_WIDTH-2:0]        b_width_i,
  input  logic [COORD_WIDTH-2:0]        b_height_i,
  input  logic [ANGLE_WIDTH-1:0]        b_angle_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          overlap_o
);
  import orso_pkg::*;

  localparam int unsigned QW = 4*16 + 6*COORD_WIDTH + 2;

  fifo_stat_t    stat;
  logic          push, pop;
  logic [QW-1:0] push_data, head;

  orso_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_left_i    (a_left_i),
    .a_top_i     (a_top_i),
    .a_width_i   (a_width_i),
    .a_height_i  (a_height_i),
    .a_angle_i   (a_angle_i),
    .b_left_i    (b_left_i),
    .b_top_i     (b_top_i),
    .b_width_i   (b_width_i),
    .b_height_i  (b_height_i),
    .b_angle_i   (b_angle_i),
    .stat_i      (stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  orso_fifo #(
    .DW (QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (stat)
  );

  orso_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .overlap_o   (overlap_o)
  );

endmodule

// File: hw/rtl/orso_sine.sv
module orso_sine (
  input  logic               clk_i,
  input  logic [1:0]         quad_i,
  input  logic [15:0]        frac_i,
  output logic signed [15:0] sin_o
);
  import orso_pkg::*;

  logic [16:0] t_d;
  logic [33:0] tt;
  logic [16:0] t1_q, z2_1_q;
  logic [1:0]  q1_q;

  logic [29:0] prod_c;
  logic [15:0] mid_d;
  logic [16:0] t2_q, z2_2_q;
  logic [15:0] mid_2_q;
  logic [1:0]  q2_q;

  logic [32:0] prod_m;
  logic [16:0] outer_d;
  logic [16:0] t3_q, outer_3_q;
  logic [1:0]  q3_q;

  logic [33:0] prod_s;
  logic [18:0] rnd;
  logic [15:0] mag;
  logic signed [15:0] sin_d, sin_q;

  // odd quadrants mirror the fraction
  assign t_d = quad_i[0] ? (17'h10000 - {1'b0, frac_i}) : {1'b0, frac_i};
  assign tt  = 34'(t_d) * 34'(t_d);

  assign prod_c = 30'(z2_1_q) * 30'(POLY_C);
  assign mid_d  = 16'(POLY_B - 17'(prod_c[29:16]));

  assign prod_m  = 33'(z2_2_q) * 33'(mid_2_q);
  assign outer_d = POLY_A - prod_m[32:16];

  assign prod_s = 34'(t3_q) * 34'(outer_3_q);
  assign rnd    = (19'(prod_s[33:16]) + 19'd1) >> 1;
  assign mag    = (rnd > 19'd32767) ? 16'd32767 : rnd[15:0];
  assign sin_d  = q3_q[1] ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk_i) begin
    t1_q      <= t_d;
    z2_1_q    <= tt[32:16];
    q1_q      <= quad_i;
    t2_q      <= t1_q;
    z2_2_q    <= z2_1_q;
    mid_2_q   <= mid_d;
    q2_q      <= q1_q;
    t3_q      <= t2_q;
    outer_3_q <= outer_d;
    q3_q      <= q2_q;
    sin_q     <= sin_d;
  end

  assign sin_o = sin_q;

endmodule

// File: hw/rtl/orso_front.sv
module orso_front #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] a_left_i,
  input  logic signed [COORD_WIDTH-1:0] a_top_i,
  input  logic [COORD_WIDTH-2:0]        a_width_i,
  input  logic [COORD_WIDTH-2:0]        a_height_i,
  input  logic [ANGLE_WIDTH-1:0]        a_angle_i,
  input  logic signed [COORD_WIDTH-1:0] b_left_i,
  input  logic signed [COORD_WIDTH-1:0] b_top_i,
  input  logic [COORD_WIDTH-2:0]        b_width_i,
  input  logic [COORD_WIDTH-2:0]        b_height_i,
  input  logic [ANGLE_WIDTH-1:0]        b_angle_i,
  input  orso_pkg::fifo_stat_t          stat_i,
  output logic                          push_o,
  output logic [4*16+6*COORD_WIDTH+1:0] push_data_o
);
  import orso_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 3;
  localparam int unsigned EW = COORD_WIDTH - 1;

  logic [31:0] a_turn, b_turn;
  logic [1:0]  quad [4];
  logic [15:0] frac [4];
  logic signed [15:0] sines [4];

  logic signed [DW-1:0] dx_d, dy_d;
  logic signed [DW-1:0] dx_q [FSTAGES];
  logic signed [DW-1:0] dy_q [FSTAGES];
  logic [EW-1:0] aw_q [FSTAGES];
  logic [EW-1:0] ah_q [FSTAGES];
  logic [EW-1:0] bw_q [FSTAGES];
  logic [EW-1:0] bh_q [FSTAGES];
  logic [FSTAGES-1:0] v_q;
  logic [QLVL_W:0] inflight, used;
  logic accept;

  assign a_turn = {a_angle_i, (32-ANGLE_WIDTH)'(0)};
  assign b_turn = {b_angle_i, (32-ANGLE_WIDTH)'(0)};

  assign quad[0] = a_turn[31:30];
  assign quad[1] = a_turn[31:30] + 2'd1;
  assign quad[2] = b_turn[31:30];
  assign quad[3] = b_turn[31:30] + 2'd1;
  assign frac[0] = a_turn[29:14];
  assign frac[1] = a_turn[29:14];
  assign frac[2] = b_turn[29:14];
  assign frac[3] = b_turn[29:14];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    orso_sine u_sine (
      .clk_i  (clk_i),
      .quad_i (quad[g]),
      .frac_i (frac[g]),
      .sin_o  (sines[g])
    );
  end

  // centre difference in 1/32 pixel
  assign dx_d = $signed({{2{a_left_i[COORD_WIDTH-1]}}, a_left_i, 1'b0})
              + $signed({4'b0, a_width_i})
              - $signed({{2{b_left_i[COORD_WIDTH-1]}}, b_left_i, 1'b0})
              - $signed({4'b0, b_width_i});
  assign dy_d = $signed({{2{a_top_i[COORD_WIDTH-1]}}, a_top_i, 1'b0})
              + $signed({4'b0, a_height_i})
              - $signed({{2{b_top_i[COORD_WIDTH-1]}}, b_top_i, 1'b0})
              - $signed({4'b0, b_height_i});

  always_comb begin
    inflight = '0;
    for (int i = 0; i < FSTAGES; i++) begin
      inflight = inflight + (QLVL_W+1)'(v_q[i]);
    end
    used = inflight + (QLVL_W+1)'(stat_i.level);
  end

  assign in_stall_o = (used >= (QLVL_W+1)'(QDEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FSTAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q[0] <= dx_d;
    dy_q[0] <= dy_d;
    aw_q[0] <= a_width_i;
    ah_q[0] <= a_height_i;
    bw_q[0] <= b_width_i;
    bh_q[0] <= b_height_i;
    for (int i = 1; i < FSTAGES; i++) begin
      dx_q[i] <= dx_q[i-1];
      dy_q[i] <= dy_q[i-1];
      aw_q[i] <= aw_q[i-1];
      ah_q[i] <= ah_q[i-1];
      bw_q[i] <= bw_q[i-1];
      bh_q[i] <= bh_q[i-1];
    end
  end

  assign push_o      = v_q[FSTAGES-1];
  assign push_data_o = {sines[0], sines[1], sines[2], sines[3],
                        dx_q[FSTAGES-1], dy_q[FSTAGES-1],
                        aw_q[FSTAGES-1], ah_q[FSTAGES-1],
                        bw_q[FSTAGES-1], bh_q[FSTAGES-1]};

endmodule

// File: hw/rtl/orso_fifo.sv
module orso_fifo #(
  parameter int unsigned DW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DW-1:0]        push_data_i,
  input  logic                 pop_i,
  output logic [DW-1:0]        head_o,
  output orso_pkg::fifo_stat_t stat_o
);
  import orso_pkg::*;

  logic [DW-1:0]     mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QLVL_W-1:0] lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      lvl_q <= lvl_q + QLVL_W'(push_i) - QLVL_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_q];
  assign stat_o.level = lvl_q;
  assign stat_o.empty = (lvl_q == '0);

endmodule

// File: hw/rtl/orso_back.sv
module orso_back #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [4*16+6*COORD_WIDTH+1:0] head_i,
  input  orso_pkg::fifo_stat_t          stat_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          overlap_o
);
  import orso_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 3;
  localparam int unsigned EW = COORD_WIDTH - 1;
  localparam int unsigned PW = DW + 16;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned HW = EW + 32;
  localparam int unsigned RW = HW + 2;

  logic signed [15:0] sa, ca, sb, cb;
  logic signed [DW-1:0] dx, dy;
  logic [EW-1:0] aw, ah, bw, bh;
  logic signed [15:0] ax [4];
  logic signed [15:0] ay [4];
  logic signed [15:0] rc [2];
  logic signed [15:0] rs [2];

  logic adv;
  logic v1_q, v2_q, v3_q, vo_q;

  // stage 1: raw products
  logic signed [31:0] cux_q [4][2];
  logic signed [31:0] suy_q [4][2];
  logic signed [31:0] sux_q [4][2];
  logic signed [31:0] cuy_q [4][2];
  logic signed [PW-1:0] dxa_q [4];
  logic signed [PW-1:0] dya_q [4];
  logic [EW-1:0] w1_q [2];
  logic [EW-1:0] h1_q [2];

  // stage 2: magnitudes
  logic signed [32:0] pe_s [4][2];
  logic signed [32:0] pf_s [4][2];
  logic signed [SW-1:0] d_s [4];
  logic [31:0] pe_q [4][2];
  logic [31:0] pf_q [4][2];
  logic [SW-1:0] d2_q [4];
  logic [EW-1:0] w2_q [2];
  logic [EW-1:0] h2_q [2];

  // stage 3: extents
  logic [HW-1:0] we_q [4][2];
  logic [HW-1:0] hf_q [4][2];
  logic [SW-1:0] d3_q [4];

  logic [RW-1:0] r_sum [4];
  logic hit_d, overlap_q;

  assign {sa, ca, sb, cb, dx, dy, aw, ah, bw, bh} = head_i;

  assign ax[0] = ca;  assign ay[0] = sa;
  assign ax[1] = -sa; assign ay[1] = ca;
  assign ax[2] = cb;  assign ay[2] = sb;
  assign ax[3] = -sb; assign ay[3] = cb;
  assign rc[0] = ca;  assign rs[0] = sa;
  assign rc[1] = cb;  assign rs[1] = sb;

  assign adv   = !vo_q || !out_stall_i;
  assign pop_o = adv && !stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 2; k++) begin
        pe_s[i][k] = 33'(cux_q[i][k]) + 33'(suy_q[i][k]);
        pf_s[i][k] = 33'(cuy_q[i][k]) - 33'(sux_q[i][k]);
      end
      d_s[i] = SW'(dxa_q[i]) + SW'(dya_q[i]);
    end
  end

  always_comb begin
    hit_d = 1'b1;
    for (int i = 0; i < 4; i++) begin
      r_sum[i] = RW'(we_q[i][0]) + RW'(hf_q[i][0]) + RW'(we_q[i][1]) + RW'(hf_q[i][1]);
      if (RW'(d3_q[i]) > (r_sum[i] >> 15)) begin
        hit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 2; k++) begin
          cux_q[i][k] <= 32'(rc[k]) * 32'(ax[i]);
          suy_q[i][k] <= 32'(rs[k]) * 32'(ay[i]);
          sux_q[i][k] <= 32'(rs[k]) * 32'(ax[i]);
          cuy_q[i][k] <= 32'(rc[k]) * 32'(ay[i]);
          pe_q[i][k]  <= pe_s[i][k][32] ? 32'(-pe_s[i][k]) : 32'(pe_s[i][k]);
          pf_q[i][k]  <= pf_s[i][k][32] ? 32'(-pf_s[i][k]) : 32'(pf_s[i][k]);
          we_q[i][k]  <= HW'(w2_q[k]) * HW'(pe_q[i][k]);
          hf_q[i][k]  <= HW'(h2_q[k]) * HW'(pf_q[i][k]);
        end
        dxa_q[i] <= PW'(dx) * PW'(ax[i]);
        dya_q[i] <= PW'(dy) * PW'(ay[i]);
        d2_q[i]  <= d_s[i][SW-1] ? SW'(-d_s[i]) : SW'(d_s[i]);
        d3_q[i]  <= d2_q[i];
      end
      w1_q[0] <= aw;
      h1_q[0] <= ah;
      w1_q[1] <= bw;
      h1_q[1] <= bh;
      w2_q    <= w1_q;
      h2_q    <= h1_q;
      overlap_q <= hit_d;
    end
  end

  assign out_valid_o = vo_q;
  assign overlap_o   = overlap_q;

endmodule

// File: hw/rtl/orso_checker.sv
module orso_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic overlap_o
);

  a_rst_no_out: assert property (@(posedge clk_i) $past(!rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  a_rst_no_stall: assert property (@(posedge clk_i) $past(!rst_ni) |-> !in_stall_o)
    else $error("input stalled right after reset");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled item dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(overlap_o))
    else $error("stalled item changed");

endmodule

bind oriented_rect_overlap_sat orso_checker u_orso_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .overlap_o   (overlap_o)
);

// File: sim/tb_oriented_rect_overlap_sat.sv
`timescale 1ns / 100ps

module tb_oriented_rect_overlap_sat;

  localparam int CW = 16;
  localparam int AW = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 1630;
  localparam int N_DIRECTED = 15;

  typedef struct {
    logic signed [CW-1:0] al, at, bl, bt;
    logic [CW-2:0]        aw, ah, bw, bh;
    logic [AW-1:0]        aa, ba;
    int                   want; // -1: use predictor
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] a_left_i = '0, a_top_i = '0, b_left_i = '0, b_top_i = '0;
  logic [CW-2:0] a_width_i = '0, a_height_i = '0, b_width_i = '0, b_height_i = '0;
  logic [AW-1:0] a_angle_i = '0, b_angle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic overlap_o;

  oriented_rect_overlap_sat dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  bit  hit_queue[$];
  int  errors = 0;
  int  cycles = 0;
  bit  feeding_done = 0;
  bit  hold_off = 0;

  function automatic longint quarter_sin(longint t);
    longint z2, inner, mid, m2, outer, s, r;
    z2 = (t * t) >>> 16;
    inner = (4640 * z2) >>> 16;
    mid = 42047 - inner;
    m2 = (z2 * mid) >>> 16;
    outer = 102944 - m2;
    s = (t * outer) >>> 16;
    r = (s + 1) >>> 1;
    if (r > 32767) r = 32767;
    return r;
  endfunction

  function automatic longint sin15(logic [31:0] turn);
    logic [1:0] q;
    longint t, s;
    q = turn[31:30];
    t = turn[29:14];
    if (q[0]) t = 65536 - t;
    s = quarter_sin(t);
    return q[1] ? -s : s;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint extent(longint w, longint h, longint c, longint s,
                                    longint ux, longint uy);
    return w * mag(c * ux + s * uy) + h * mag(-s * ux + c * uy);
  endfunction

  function automatic bit rects_collide(pair_t p);
    logic [31:0] ta, tb;
    longint sa, ca, sb, cb, dx, dy, d, r;
    longint ux[4], uy[4];
    bit hit;
    ta = {p.aa, {(32-AW){1'b0}}};
    tb = {p.ba, {(32-AW){1'b0}}};
    sa = sin15(ta); ca = sin15(ta + 32'h4000_0000);
    sb = sin15(tb); cb = sin15(tb + 32'h4000_0000);
    dx = (2 * longint'(p.al) + longint'(p.aw)) - (2 * longint'(p.bl) + longint'(p.bw));
    dy = (2 * longint'(p.at) + longint'(p.ah)) - (2 * longint'(p.bt) + longint'(p.bh));
    ux[0] = ca;  uy[0] = sa;
    ux[1] = -sa; uy[1] = ca;
    ux[2] = cb;  uy[2] = sb;
    ux[3] = -sb; uy[3] = cb;
    hit = 1;
    for (int i = 0; i < 4; i++) begin
      d = mag(dx * ux[i] + dy * uy[i]);
      r = extent(p.aw, p.ah, ca, sa, ux[i], uy[i]) + extent(p.bw, p.bh, cb, sb, ux[i], uy[i]);
      if (d > (r >>> 15)) hit = 0;
    end
    return hit;
  endfunction

  function automatic pair_t mk(int al, int at, int aw, int ah, int aa,
                               int bl, int bt, int bw, int bh, int ba, int want);
    pair_t p;
    p.al = al; p.at = at; p.aw = aw; p.ah = ah; p.aa = aa;
    p.bl = bl; p.bt = bt; p.bw = bw; p.bh = bh; p.ba = ba;
    p.want = want;
    return p;
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int span;
    p.want = -1;
    p.aa = $urandom; p.ba = $urandom;
    case ($urandom_range(0, 3))
      0: begin
        p.al = $urandom; p.at = $urandom; p.bl = $urandom; p.bt = $urandom;
        p.aw = $urandom; p.ah = $urandom; p.bw = $urandom; p.bh = $urandom;
      end
      default: begin
        // near misses: sizes and offsets on the same scale
        span = 1 << $urandom_range(4, 13);
        p.aw = $urandom_range(0, span); p.ah = $urandom_range(0, span);
        p.bw = $urandom_range(0, span); p.bh = $urandom_range(0, span);
        p.al = $urandom_range(0, 65535) - 32768;
        p.at = $urandom_range(0, 65535) - 32768;
        p.bl = p.al + int'($urandom_range(0, 2 * span)) - span;
        p.bt = p.at + int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    return p;
  endfunction

  task automatic offer(pair_t p);
    bit exp_hit;
    a_left_i <= p.al; a_top_i <= p.at; a_width_i <= p.aw; a_height_i <= p.ah;
    a_angle_i <= p.aa; b_left_i <= p.bl; b_top_i <= p.bt; b_width_i <= p.bw;
    b_height_i <= p.bh; b_angle_i <= p.ba;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (p.want >= 0) exp_hit = p.want[0];
    else exp_hit = rects_collide(p);
    hit_queue = {hit_queue, exp_hit};
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  pair_t directed[N_DIRECTED];

  initial begin
    directed[0]  = mk(0, 0, 16, 16, 0, 0, 0, 16, 16, 0, 1);
    directed[1]  = mk(0, 0, 16, 16, 0, 16, 0, 16, 16, 0, -1);
    directed[2]  = mk(0, 0, 16, 16, 0, 17, 0, 16, 16, 0, 0);
    directed[3]  = mk(-32768, -32768, 1, 1, 0, 32767, 32767, 1, 1, 0, 0);
    directed[4]  = mk(-32768, -32768, 32767, 32767, 0, 0, 0, 32767, 32767, 0, 0);
    directed[5]  = mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    directed[6]  = mk(0, 0, 0, 100, 16384, 50, 50, 0, 0, 0, -1);
    directed[7]  = mk(0, 0, 100, 0, 16384, 0, 0, 100, 0, 49152, -1);
    directed[8]  = mk(0, 0, 100, 20, 8192, 90, 0, 20, 100, 57344, -1);
    directed[9]  = mk(0, 0, 32767, 1, 32768, 100, 100, 1, 32767, 65535, -1);
    directed[10] = mk(32767, 32767, 32767, 32767, 65535, -32768, -32768, 32767,
                      32767, 1, -1);
    directed[11] = mk(-1, -1, 21845, 10922, 43690, 21845, 21845, 10922, 21845,
                      21845, -1);
    directed[12] = mk(100, 200, 300, 40, 4000, 250, 220, 60, 300, 30000, -1);
    directed[13] = mk(0, 0, 64, 64, 8192, 80, 0, 64, 64, 8192, -1);
    directed[14] = mk(0, 0, 64, 64, 8192, 92, 0, 64, 64, 0, -1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) offer(directed[i]);
    for (int n = 0; n < N_RANDOM; n++) begin
      offer(rand_pair());
      pause_sender();
      if (n == 400) hold_off = 1;
    end
    in_valid_i <= 1'b0;
    feeding_done = 1;
  end

  // receiver stalls, including one long hold-off while the sender keeps going
  initial begin
    int len;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_off = 0;
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
      end
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) len = 0;
      out_stall_i <= (len > 0);
      if (len > 1) repeat (len - 1) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (hit_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result overlap=%0b", overlap_o);
      end else begin
        bit want;
        want = hit_queue.pop_front();
        if (overlap_o !== want) begin
          errors++;
          if (errors <= 10) $display("overlap mismatch: expected %0b got %0b", want, overlap_o);
        end
      end
    end
  end

  initial begin
    wait (feeding_done);
    while (hit_queue.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && hit_queue.size() == 0) $display("PASS oriented_rect_overlap_sat");
    else $display("FAIL oriented_rect_overlap_sat");
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL oriented_rect_overlap_sat");
      $finish;
    end
  end

endmodule
